FILE: src/sof_eof_esc_byte_stuffer_macros.svh
// ----------------------------------------------------------------------------
// sof_eof_esc_byte_stuffer_macros
// Assertion helpers shared by the byte stuffer RTL.
// ----------------------------------------------------------------------------
`ifndef SOF_EOF_ESC_BYTE_STUFFER_MACROS_SVH
`define SOF_EOF_ESC_BYTE_STUFFER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SOFESC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sofesc assertion failed");

// next-cycle implication, disabled while reset is asserted
`define SOFESC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sofesc assertion failed");

`endif

FILE: src/sofesc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sofesc_pkg
// Types and constants of the SOF/EOF/ESC byte stuffer.
// ----------------------------------------------------------------------------
package sofesc_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned MaxOut   = 4;
  localparam int unsigned OutIdxW  = $clog2(MaxOut);
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [ByteW-1:0] SofReset = 8'hA1;
  localparam logic [ByteW-1:0] EofReset = 8'hA2;
  localparam logic [ByteW-1:0] EscReset = 8'hA3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SOF = 2'd0,
    CFG_EOF = 2'd1,
    CFG_ESC = 2'd2
  } cfg_idx_e;

  // output sequence produced by one input byte
  typedef struct packed {
    logic [MaxOut-1:0][ByteW-1:0] bytes;
    logic [OutIdxW-1:0]           last_idx;
    logic                         has_eof;
  } seq_t;

endpackage

FILE: src/sofesc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sofesc_if
// Valid/ready channels for payload bytes in and stuffed bytes out.
// ----------------------------------------------------------------------------
interface sofesc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface sofesc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_done;

  modport source (output valid, output out_byte, output run_last, output frame_done,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input frame_done,
                  output ready);
endinterface

FILE: src/sofesc_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sofesc_encoder
// Builds the up to four line bytes caused by one payload byte.
// ----------------------------------------------------------------------------
module sofesc_encoder
  import sofesc_pkg::*;
(
  input  logic [ByteW-1:0] data_i,
  input  logic             final_i,
  input  logic             in_frame_i,
  input  logic [ByteW-1:0] sof_i,
  input  logic [ByteW-1:0] eof_i,
  input  logic [ByteW-1:0] esc_i,
  output seq_t             seq_o
);

  logic               need_esc;
  logic [OutIdxW-1:0] pos_data;
  logic [OutIdxW-1:0] pos_inv;
  logic [OutIdxW-1:0] pos_eof;

  assign need_esc = (data_i == sof_i) || (data_i == eof_i) || (data_i == esc_i);
  assign pos_data = {1'b0, ~in_frame_i};
  assign pos_inv  = pos_data + OutIdxW'(1);
  assign pos_eof  = pos_data + {1'b0, need_esc} + OutIdxW'(1);

  always_comb begin
    seq_o = '0;
    for (int i = 0; i < MaxOut; i++) begin
      if (i == 0 && !in_frame_i) begin
        seq_o.bytes[i] = sof_i;
      end else if (OutIdxW'(i) == pos_data) begin
        seq_o.bytes[i] = need_esc ? esc_i : data_i;
      end else if (need_esc && OutIdxW'(i) == pos_inv) begin
        seq_o.bytes[i] = ~data_i;
      end else if (final_i && OutIdxW'(i) == pos_eof) begin
        seq_o.bytes[i] = eof_i;
      end
    end
    seq_o.last_idx = pos_data + {1'b0, need_esc} + {1'b0, final_i};
    seq_o.has_eof  = final_i;
  end

endmodule

FILE: src/sof_eof_esc_byte_stuffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sof_eof_esc_byte_stuffer
// Frames payload bytes with start/end markers and escapes special bytes.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one payload byte per transfer plus final_byte on the last
//   byte of a frame. out_if carries one line byte per transfer; run_last
//   marks the last line byte of an input, frame_done the end marker.
//   The user writes the marker and escape values via cfg_we_i / cfg_idx_i /
//   cfg_wdata_i while idle, unchecked by the block; an unused index is ignored.
// Latency and throughput:
//   an accepted byte is presented on out_if in the next cycle. Each input
//   yields 1 to 4 line bytes, sent one per cycle from a sequence register
//   while out_if.ready is high. A new input is taken in the cycle the last
//   byte of the previous one transfers, so the line side does not idle
//   while inputs keep arriving.
// Reset:
//   sets the marker registers to 0xA1/0xA2/0xA3, closes any open frame and
//   empties the output stage.
// Stall:
//   while out_if.ready is low the current byte holds and, while busy, no input is taken.
// ----------------------------------------------------------------------------
`include "sof_eof_esc_byte_stuffer_macros.svh"

module sof_eof_esc_byte_stuffer
  import sofesc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ByteW-1:0]   cfg_wdata_i,
  sofesc_in_if.sink          in_if,
  sofesc_out_if.source       out_if
);

  logic [ByteW-1:0]   sof_q, eof_q, esc_q;
  logic               in_frame_q, in_frame_d;
  logic               busy_q, busy_d;
  logic [OutIdxW-1:0] idx_q, idx_d;
  seq_t               seq_q, seq_d;
  seq_t               enc_seq;
  logic               in_xfer, out_xfer, is_last, last_xfer;

  sofesc_encoder u_encoder (
    .data_i     (in_if.data_byte),
    .final_i    (in_if.final_byte),
    .in_frame_i (in_frame_q),
    .sof_i      (sof_q),
    .eof_i      (eof_q),
    .esc_i      (esc_q),
    .seq_o      (enc_seq)
  );

  assign is_last   = (idx_q == seq_q.last_idx);
  assign out_xfer  = out_if.valid && out_if.ready;
  assign last_xfer = out_xfer && is_last;
  assign in_if.ready = !busy_q || last_xfer;
  assign in_xfer   = in_if.valid && in_if.ready;

  assign out_if.valid      = busy_q;
  assign out_if.out_byte   = seq_q.bytes[idx_q];
  assign out_if.run_last   = is_last;
  assign out_if.frame_done = is_last && seq_q.has_eof;

  always_comb begin
    busy_d     = busy_q;
    idx_d      = idx_q;
    seq_d      = seq_q;
    in_frame_d = in_frame_q;
    if (in_xfer) begin
      busy_d     = 1'b1;
      idx_d      = '0;
      seq_d      = enc_seq;
      in_frame_d = !in_if.final_byte;
    end else if (last_xfer) begin
      busy_d = 1'b0;
    end else if (out_xfer) begin
      idx_d = idx_q + OutIdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sof_q      <= SofReset;
      eof_q      <= EofReset;
      esc_q      <= EscReset;
      in_frame_q <= 1'b0;
      busy_q     <= 1'b0;
      idx_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SOF: sof_q <= cfg_wdata_i;
          CFG_EOF: eof_q <= cfg_wdata_i;
          CFG_ESC: esc_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      in_frame_q <= in_frame_d;
      busy_q     <= busy_d;
      idx_q      <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q <= seq_d;
  end

  `SOFESC_ASSERT_NXT(a_drain_idle, clk_i, rst_ni, last_xfer && !in_xfer, !busy_q)
  `SOFESC_ASSERT_NXT(a_stall_hold, clk_i, rst_ni, busy_q && !out_if.ready,
                     busy_q && $stable(idx_q))
  `SOFESC_ASSERT_NXT(a_final_close, clk_i, rst_ni, in_xfer && in_if.final_byte,
                     !in_frame_q && busy_q && seq_q.has_eof)
  `SOFESC_ASSERT_IMP(a_idx_range, clk_i, rst_ni, busy_q, idx_q <= seq_q.last_idx)

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the SOF/EOF/ESC byte stuffer. A short table of
// payload bytes and register writes opens the run, then random frames follow
// under several marker settings and with sender gaps and receiver stalls.
// Every line byte is checked against typed plan bytes or a behavioral copy.
// ----------------------------------------------------------------------------
module testbench;
  import sofesc_pkg::*;

  localparam int unsigned MaxCycles = 200000;
  localparam int unsigned ShowErrs  = 10;
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             run_last;
    logic             frame_done;
  } line_byte_t;

  // line bytes caused by one payload byte
  typedef struct packed {
    logic [2:0]                    count;
    line_byte_t [MaxOut-1:0]       b;
  } stuffed_t;

  // one row of the directed plan: a register write or a payload byte,
  // with the line bytes typed in where n_typed is nonzero (first byte on top)
  typedef struct packed {
    logic               is_cfg;
    logic [CfgIdxW-1:0] idx;
    logic [ByteW-1:0]   val;
    logic               fin;
    logic [2:0]         n_typed;
    logic [31:0]        typed;
  } plan_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [ByteW-1:0]   cfg_wdata_i;

  sofesc_in_if  in_if ();
  sofesc_out_if out_if ();

  sof_eof_esc_byte_stuffer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_if),
    .out_if      (out_if)
  );

  // behavioral copy of the block
  logic [ByteW-1:0] mark_sof;
  logic [ByteW-1:0] mark_eof;
  logic [ByteW-1:0] mark_esc;
  logic             frame_open;

  line_byte_t line_q[$];
  plan_row_t  plan[$];

  int unsigned in_pct;
  int unsigned out_pct;
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned payload_cnt;
  int unsigned escape_cnt;
  int unsigned frame_cnt;
  int unsigned line_cnt;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic stuffed_t stuff_payload(input logic [ByteW-1:0] d, input logic fin);
    stuffed_t s;
    s = '0;
    if (!frame_open) begin
      s.b[2'(s.count)].out_byte = mark_sof;
      s.count = s.count + 3'd1;
      frame_open = 1'b1;
    end
    if (d == mark_sof || d == mark_eof || d == mark_esc) begin
      s.b[2'(s.count)].out_byte = mark_esc;
      s.count = s.count + 3'd1;
      s.b[2'(s.count)].out_byte = ~d;
      s.count = s.count + 3'd1;
      escape_cnt++;
    end else begin
      s.b[2'(s.count)].out_byte = d;
      s.count = s.count + 3'd1;
    end
    if (fin) begin
      s.b[2'(s.count)].out_byte = mark_eof;
      s.b[2'(s.count)].frame_done = 1'b1;
      s.count = s.count + 3'd1;
      frame_open = 1'b0;
      frame_cnt++;
    end
    s.b[2'(s.count - 3'd1)].run_last = 1'b1;
    return s;
  endfunction

  function automatic logic [ByteW-1:0] any_reg_value();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= ShowErrs) $display("mismatch: %s", msg);
  endtask

  task automatic add_item(input logic [ByteW-1:0] d, input logic fin, input logic [2:0] n,
                          input logic [31:0] typed);
    plan_row_t r;
    r = '0;
    r.val = d;
    r.fin = fin;
    r.n_typed = n;
    r.typed = typed;
    plan.push_back(r);
  endtask

  task automatic add_cfg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    plan.push_back(r);
  endtask

  // stop sending and wait until every expected line byte has transferred
  task automatic drain_line();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (line_q.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    drain_line();
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_SOF: mark_sof = val;
      CFG_EOF: mark_eof = val;
      CFG_ESC: mark_esc = val;
      default: ;
    endcase
  endtask

  task automatic send_payload(input plan_row_t r);
    stuffed_t s;
    @(negedge clk_i);
    while ($urandom_range(99) < in_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.data_byte = r.val;
    in_if.final_byte = r.fin;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    s = stuff_payload(r.val, r.fin);
    if (r.n_typed != 0) begin
      s = '0;
      s.count = r.n_typed;
      for (int k = 0; k < r.n_typed; k++) s.b[k].out_byte = r.typed[31 - 8 * k -: 8];
      s.b[2'(r.n_typed - 3'd1)].run_last = 1'b1;
      s.b[2'(r.n_typed - 3'd1)].frame_done = r.fin;
    end
    for (int k = 0; k < s.count; k++) line_q.push_back(s.b[k]);
    payload_cnt++;
  endtask

  task automatic pick_setting();
    write_reg(CFG_SOF, any_reg_value());
    write_reg(CFG_EOF, any_reg_value());
    write_reg(CFG_ESC, any_reg_value());
    // equal markers now and then
    if ($urandom_range(3) == 0) write_reg(CFG_ESC, mark_eof);
    if ($urandom_range(2) == 0) write_reg(CfgUnused, 8'($urandom_range(255)));
  endtask

  // random frames, mostly of a few bytes, biased toward marker values
  task automatic random_frames(input int n);
    plan_row_t        r;
    logic [ByteW-1:0] mk;
    int               left;
    int               pick;
    left = 0;
    for (int i = 0; i < n; i++) begin
      r = '0;
      if (left == 0) left = ($urandom_range(3) == 0) ? 1 : $urandom_range(6, 2);
      pick = $urandom_range(2);
      mk = (pick == 0) ? mark_sof : (pick == 1) ? mark_eof : mark_esc;
      pick = $urandom_range(19);
      if (pick < 7) r.val = mk;
      else if (pick < 9) r.val = ~mk;
      else r.val = 8'($urandom_range(255));
      left--;
      r.fin = (left == 0);
      send_payload(r);
    end
  endtask

  // line side receiver
  always @(negedge clk_i) begin
    if ($urandom_range(99) < out_pct) out_if.ready <= 1'b0;
    else out_if.ready <= 1'b1;
  end

  always @(posedge clk_i) begin
    line_byte_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      line_cnt++;
      if (line_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected line byte %02h run_last %0b frame_done %0b",
                                out_if.out_byte, out_if.run_last, out_if.frame_done));
      end else begin
        want = line_q.pop_front();
        if (out_if.out_byte !== want.out_byte || out_if.run_last !== want.run_last ||
            out_if.frame_done !== want.frame_done) begin
          flag_mismatch($sformatf("expected %02h/%0b/%0b got %02h/%0b/%0b (byte/last/done)",
                                  want.out_byte, want.run_last, want.frame_done,
                                  out_if.out_byte, out_if.run_last, out_if.frame_done));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > MaxCycles) begin
      $display("timeout after %0d cycles, %0d line bytes still expected", cycle_cnt,
               line_q.size());
      $display("FAIL sof_eof_esc_byte_stuffer");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_SOF;
    cfg_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.final_byte = 1'b0;
    out_if.ready = 1'b0;
    in_pct = 0;
    out_pct = 0;
    err_cnt = 0;
    cycle_cnt = 0;
    payload_cnt = 0;
    escape_cnt = 0;
    frame_cnt = 0;
    line_cnt = 0;
    mark_sof = SofReset;
    mark_eof = EofReset;
    mark_esc = EscReset;
    frame_open = 1'b0;

    // reset markers
    add_item(8'h00, 1'b0, 3'd2, 32'hA100_0000);
    add_item(8'hFF, 1'b0, 3'd1, 32'hFF00_0000);
    add_item(8'hA1, 1'b0, 3'd2, 32'hA35E_0000);
    add_item(8'hA2, 1'b0, 3'd2, 32'hA35D_0000);   // payload end marker, no frame_done
    add_item(8'hA3, 1'b1, 3'd3, 32'hA35C_A200);
    add_item(8'hA2, 1'b1, 3'd4, 32'hA1A3_5DA2);   // single-byte frame, four line bytes
    add_item(8'h55, 1'b1, 3'd3, 32'hA155_A200);
    add_item(8'h5E, 1'b0, 3'd2, 32'hA15E_0000);
    add_item(8'h3C, 1'b0, 3'd0, '0);
    add_item(8'hC3, 1'b1, 3'd0, '0);
    // inverted byte equal to the start marker goes out unescaped
    add_cfg(CFG_SOF, 8'h5D);
    add_item(8'hA2, 1'b1, 3'd4, 32'h5DA3_5DA2);
    // end and escape markers equal
    add_cfg(CFG_SOF, 8'hFF);
    add_cfg(CFG_EOF, 8'h00);
    add_cfg(CFG_ESC, 8'h00);
    add_item(8'h00, 1'b1, 3'd4, 32'hFF00_FF00);
    add_item(8'hFF, 1'b0, 3'd3, 32'hFF00_0000);
    add_item(8'h80, 1'b0, 3'd0, '0);
    add_item(8'h01, 1'b1, 3'd0, '0);
    // unused index, write has no effect
    add_cfg(CfgUnused, 8'h5A);
    add_item(8'h5A, 1'b1, 3'd3, 32'hFF5A_0000);
    add_cfg(CFG_SOF, 8'h00);
    add_cfg(CFG_EOF, 8'hFF);
    add_cfg(CFG_ESC, 8'hFF);
    add_item(8'hFF, 1'b1, 3'd0, '0);
    add_item(8'h00, 1'b0, 3'd0, '0);
    add_item(8'h7E, 1'b1, 3'd0, '0);
    add_cfg(CFG_SOF, SofReset);
    add_cfg(CFG_EOF, EofReset);
    add_cfg(CFG_ESC, EscReset);
    add_item(8'h5C, 1'b1, 3'd0, '0);

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].idx, plan[i].val);
      else send_payload(plan[i]);
    end

    // no idling, sender gaps, receiver stalls, then both lightly
    for (int ph = 0; ph < 4; ph++) begin
      drain_line();
      in_pct = (ph == 1) ? 73 : (ph == 3) ? 27 : 0;
      out_pct = (ph == 2) ? 73 : (ph == 3) ? 27 : 0;
      repeat (2) begin
        pick_setting();
        random_frames(14);
      end
    end

    drain_line();
    repeat (8) @(negedge clk_i);
    $display("covered %0d payload bytes, %0d closed frames, %0d escapes, %0d line bytes",
             payload_cnt, frame_cnt, escape_cnt, line_cnt);
    $display("mismatches: %0d, cycles: %0d", err_cnt, cycle_cnt);
    if (err_cnt == 0) begin
      $display("PASS sof_eof_esc_byte_stuffer");
    end else begin
      $display("FAIL sof_eof_esc_byte_stuffer");
    end
    $finish;
  end

endmodule
